// ----- hw/rtl/mace6_pkg.sv -----
// shared types, constants, slope tables and helper functions for the 6:1 audio decoder
package mace6_pkg;

    // which code of the byte is being decoded
    localparam logic [1:0] CODE_HI  = 2'd0;
    localparam logic [1:0] CODE_MID = 2'd1;
    localparam logic [1:0] CODE_LO  = 2'd2;

    localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic [7:0]         SIGN_FLIP  = 8'h80;

    typedef struct packed {
        logic       load;       // capture byte, apply restart
        logic       step;       // table lookup, new index and sample
        logic       energy;     // energy update and smoothed pair
        logic [1:0] code_sel;
        logic       publish;    // move finished bytes to the output register
    } mace6_cmd_t;

    typedef logic [7:0] pcm_byte_t;

    // per-code index moves
    localparam logic signed [8:0] STEP2_ADJ [4] = '{-18, 140, 140, -18};
    localparam logic signed [8:0] STEP3_ADJ [8] = '{-13, 8, 76, 222, 222, 76, 8, -13};

    // positive half of each row; the negative half is the bitwise inverse
    localparam logic [14:0] SLOPE2_ROM [128][2] = '{
        '{64,216},'{67,226},'{70,236},'{74,246},'{77,257},'{80,268},'{84,280},'{88,294},
        '{92,307},'{96,321},'{100,334},'{104,350},'{109,365},'{114,382},'{119,399},'{124,416},
        '{130,434},'{136,454},'{142,475},'{148,495},'{155,519},'{162,541},'{169,564},'{176,590},
        '{185,617},'{193,644},'{201,673},'{210,703},'{220,735},'{230,767},'{240,801},'{251,838},
        '{262,876},'{274,914},'{286,955},'{299,997},'{312,1041},'{326,1089},'{341,1138},
        '{356,1188},
        '{372,1241},'{388,1297},'{406,1354},'{424,1415},'{443,1478},'{462,1544},'{483,1613},
        '{505,1684},
        '{527,1760},'{551,1838},'{576,1921},'{601,2007},'{628,2097},'{656,2190},'{686,2288},
        '{716,2389},
        '{748,2496},'{781,2607},'{816,2724},'{853,2846},'{891,2973},'{930,3104},'{972,3243},
        '{1016,3389},
        '{1061,3539},'{1108,3698},'{1158,3862},'{1209,4035},'{1264,4216},'{1320,4403},
        '{1379,4599},'{1441,4806},
        '{1505,5019},'{1572,5244},'{1642,5477},'{1715,5722},'{1792,5978},'{1872,6245},
        '{1955,6522},'{2043,6813},
        '{2134,7118},'{2229,7436},'{2329,7767},'{2432,8114},'{2541,8477},'{2655,8854},
        '{2773,9250},'{2897,9663},
        '{3026,10094},'{3162,10546},'{3303,11016},'{3450,11508},'{3604,12020},'{3765,12556},
        '{3933,13118},'{4108,13703},
        '{4292,14315},'{4483,14953},'{4683,15621},'{4892,16318},'{5111,17046},'{5339,17807},
        '{5577,18602},'{5826,19433},
        '{6086,20300},'{6358,21205},'{6642,22152},'{6938,23141},'{7248,24173},'{7571,25252},
        '{7909,26380},'{8262,27557},
        '{8631,28786},'{9016,30072},'{9419,31413},'{9839,32767},'{10278,32767},'{10737,32767},
        '{11216,32767},'{11717,32767},
        '{12240,32767},'{12786,32767},'{13356,32767},'{13953,32767},'{14576,32767},
        '{15226,32767},'{15906,32767},'{16615,32767}
    };

    localparam logic [14:0] SLOPE3_ROM [128][4] = '{
        '{37,116,206,330},'{39,121,216,346},'{41,127,225,361},'{42,132,235,377},
        '{44,137,245,392},'{46,144,256,410},'{48,150,267,428},'{51,157,280,449},
        '{53,165,293,470},'{55,172,306,490},'{58,179,319,511},'{60,187,333,534},
        '{63,195,348,557},'{66,205,364,583},'{69,214,380,609},'{72,223,396,635},
        '{75,233,414,663},'{79,244,433,694},'{82,254,453,725},'{86,265,472,756},
        '{90,278,495,792},'{94,290,516,826},'{98,303,538,862},'{102,316,562,901},
        '{107,331,588,942},'{112,345,614,983},'{117,361,641,1027},'{122,377,670,1074},
        '{127,394,701,1123},'{133,411,732,1172},'{139,430,764,1224},'{145,449,799,1280},
        '{152,469,835,1337},'{159,490,872,1397},'{166,512,911,1459},'{173,535,951,1523},
        '{181,558,993,1590},'{189,584,1038,1663},'{197,610,1085,1738},'{206,637,1133,1815},
        '{215,665,1183,1895},'{225,695,1237,1980},'{235,726,1291,2068},'{246,759,1349,2161},
        '{257,792,1409,2257},'{268,828,1472,2357},'{280,865,1538,2463},'{293,903,1606,2572},
        '{306,944,1678,2688},'{319,986,1753,2807},'{334,1030,1832,2933},'{349,1076,1914,3065},
        '{364,1124,1999,3202},'{380,1174,2088,3344},'{398,1227,2182,3494},'{415,1281,2278,3649},
        '{434,1339,2380,3811},'{453,1398,2486,3982},'{473,1461,2598,4160},'{495,1526,2714,4346},
        '{517,1594,2835,4540},'{540,1665,2961,4741},'{564,1740,3093,4953},'{589,1818,3232,5175},
        '{615,1898,3375,5405},'{643,1984,3527,5647},'{671,2072,3683,5898},'{701,2164,3848,6161},
        '{733,2261,4020,6438},'{766,2362,4199,6724},'{800,2467,4386,7024},'{836,2578,4583,7339},
        '{873,2692,4786,7664},'{912,2813,5001,8008},'{952,2938,5223,8364},'{995,3070,5457,8739},
        '{1039,3207,5701,9129},'{1086,3350,5956,9537},'{1134,3499,6220,9960},
        '{1185,3655,6497,10404},
        '{1238,3818,6788,10869},'{1293,3989,7091,11355},'{1351,4166,7407,11861},
        '{1411,4352,7738,12390},
        '{1474,4547,8084,12946},'{1540,4750,8444,13522},'{1609,4962,8821,14126},
        '{1680,5183,9215,14756},
        '{1756,5415,9626,15415},'{1834,5657,10057,16104},'{1916,5909,10505,16822},
        '{2001,6173,10975,17574},
        '{2091,6448,11463,18356},'{2184,6736,11974,19175},'{2282,7037,12510,20032},
        '{2383,7351,13068,20926},
        '{2490,7679,13652,21861},'{2601,8021,14260,22834},'{2717,8380,14897,23854},
        '{2838,8753,15561,24918},
        '{2965,9144,16256,26031},'{3097,9553,16982,27193},'{3236,9979,17740,28407},
        '{3380,10424,18532,29675},
        '{3531,10890,19359,31000},'{3688,11375,20222,32382},'{3853,11883,21125,32767},
        '{4025,12414,22069,32767},
        '{4205,12967,23053,32767},'{4392,13546,24082,32767},'{4589,14151,25157,32767},
        '{4793,14783,26280,32767},
        '{5007,15442,27452,32767},'{5231,16132,28678,32767},'{5464,16851,29957,32767},
        '{5708,17603,31294,32767},
        '{5963,18389,32691,32767},'{6229,19210,32767,32767},'{6507,20067,32767,32767},
        '{6797,20963,32767,32767},
        '{7101,21899,32767,32767},'{7418,22876,32767,32767},'{7749,23897,32767,32767},
        '{8095,24964,32767,32767},
        '{8456,26078,32767,32767},'{8833,27242,32767,32767},'{9228,28457,32767,32767},
        '{9639,29727,32767,32767}
    };

    // saturate to +-32767
    function automatic logic signed [15:0] sat_sample(input logic signed [18:0] v);
        logic signed [15:0] r;
        if (v > 19'sd32767) begin
            r = SAMPLE_MAX;
        end else if (v < -19'sd32767) begin
            r = -SAMPLE_MAX;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // high byte of the saturated value, made unsigned
    function automatic pcm_byte_t to_pcm(input logic signed [18:0] v);
        logic signed [15:0] c;
        c = sat_sample(v);
        return c[15:8] ^ SIGN_FLIP;
    endfunction

endpackage

// ----- hw/rtl/mace6_ctrl.sv -----
// controller state machine: sequences the three codes of a byte and the result handshake
module mace6_ctrl
    import mace6_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    output mace6_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_ENERGY,
        ST_PUB
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] code_reg, code_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        code_next    = code_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        cmd.code_sel = code_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    code_next  = CODE_HI;
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                cmd.step   = 1'b1;
                state_next = ST_ENERGY;
            end
            ST_ENERGY: begin
                cmd.energy = 1'b1;
                if (code_reg == CODE_LO) begin
                    state_next = ST_PUB;
                end else begin
                    code_next  = code_reg + 2'd1;
                    state_next = ST_STEP;
                end
            end
            ST_PUB: begin
                // hold the finished bytes until the output register is free
                if (out_free) begin
                    cmd.publish  = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            code_reg    <= CODE_HI;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            code_reg    <= code_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ----- hw/rtl/mace6_dp.sv -----
// datapath: step index, slope lookup, energy multiply, smoothing and output bytes
module mace6_dp
    import mace6_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  mace6_cmd_t cmd,
    input  logic [7:0] s_code_byte,
    input  logic       s_restart,
    output pcm_byte_t  pcm_out [6]
);

    logic [7:0]         byte_reg;
    logic [15:0]        step_reg, step_next;
    logic [14:0]        energy_reg;
    logic signed [15:0] samp_reg, samp_next;
    logic signed [15:0] p1_reg, p2_reg;
    pcm_byte_t          work_reg [6];
    pcm_byte_t          out_reg [6];

    logic [2:0]         code;
    logic               wide;
    logic [6:0]         row;
    logic signed [15:0] slope;
    logic signed [8:0]  adj;
    logic signed [17:0] idx_sum;
    logic signed [18:0] samp_sum;
    logic signed [31:0] square;
    logic signed [17:0] p2_x3, t_x3;
    logic signed [18:0] smooth_a, smooth_b;
    logic [2:0]         lo_idx, hi_idx;

    // code extraction
    always_comb begin
        case (cmd.code_sel)
            CODE_HI: begin
                code = byte_reg[7:5];
                wide = 1'b1;
            end
            CODE_MID: begin
                code = {1'b0, byte_reg[4:3]};
                wide = 1'b0;
            end
            CODE_LO: begin
                code = byte_reg[2:0];
                wide = 1'b1;
            end
            default: begin
                code = byte_reg[7:5];
                wide = 1'b1;
            end
        endcase
    end

    assign row = step_reg[10:4];

    always_comb begin
        if (wide) begin
            adj   = STEP3_ADJ[code];
            slope = code[2] ? ~{1'b0, SLOPE3_ROM[row][~code[1:0]]}
                            :  {1'b0, SLOPE3_ROM[row][code[1:0]]};
        end else begin
            adj   = STEP2_ADJ[code[1:0]];
            slope = code[1] ? ~{1'b0, SLOPE2_ROM[row][~code[0]]}
                            :  {1'b0, SLOPE2_ROM[row][code[0]]};
        end
        idx_sum = $signed({2'b00, step_reg}) + 18'(adj)
                  - $signed({7'd0, step_reg[15:5]});
        step_next = idx_sum[17] ? 16'd0 : idx_sum[15:0];
        samp_sum  = 19'(slope) + $signed({4'd0, energy_reg});
        samp_next = sat_sample(samp_sum);
    end

    // sample is at most 32767 in magnitude, so the square fits in 30 bits
    assign square = samp_reg * samp_reg;

    always_comb begin
        p2_x3    = 18'(p2_reg) + 18'(p2_reg) + 18'(p2_reg);
        t_x3     = 18'(samp_reg) + 18'(samp_reg) + 18'(samp_reg);
        smooth_a = 19'(samp_reg >>> 3) + 19'(p2_x3 >>> 3) + 19'(p1_reg >>> 1);
        smooth_b = 19'(p2_reg >>> 3) + 19'(t_x3 >>> 3) + 19'(p1_reg >>> 1);
        lo_idx   = {cmd.code_sel, 1'b0};
        hi_idx   = {cmd.code_sel, 1'b1};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg   <= '0;
            energy_reg <= '0;
            p1_reg     <= '0;
            p2_reg     <= '0;
        end else begin
            if (cmd.load && s_restart) begin
                step_reg   <= '0;
                energy_reg <= '0;
                p1_reg     <= '0;
                p2_reg     <= '0;
            end
            if (cmd.step) begin
                step_reg <= step_next;
            end
            if (cmd.energy) begin
                energy_reg <= square[29:15];
                p2_reg     <= p1_reg;
                p1_reg     <= samp_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            byte_reg <= s_code_byte;
        end
        if (cmd.step) begin
            samp_reg <= samp_next;
        end
        if (cmd.energy) begin
            work_reg[lo_idx] <= to_pcm(smooth_a);
            work_reg[hi_idx] <= to_pcm(smooth_b);
        end
        if (cmd.publish) begin
            out_reg <= work_reg;
        end
    end

    assign pcm_out = out_reg;

endmodule

// ----- hw/rtl/mace6_audio_decoder.sv -----
// 6:1 compressed audio decoder, top level
//
// input channel: one compressed byte per transaction (s_code_byte) plus
// s_restart, which zeroes the step index, energy and sample history before
// the byte is decoded. output channel: one transaction per input byte,
// carrying six unsigned 8-bit samples m_pcm_out0..m_pcm_out5 in time order.
//
// each byte holds three codes decoded one after another; each code passes
// a step state (slope lookup and new sample), then an energy state (the
// energy multiply and the smoothed pair), and its energy feeds the next
// code's sample. a new byte is taken only after the result is published.
//
// reset (aresetn low, synchronous) clears the step index, energy, sample
// history and controller state and drops m_valid. the output register
// holds a finished result while the receiver stalls; the next byte is
// still taken and decoded, and waits in the datapath until the output
// register frees up, with s_ready low meanwhile.
module mace6_audio_decoder
    import mace6_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_code_byte,
    input  logic       s_restart,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_pcm_out0,
    output logic [7:0] m_pcm_out1,
    output logic [7:0] m_pcm_out2,
    output logic [7:0] m_pcm_out3,
    output logic [7:0] m_pcm_out4,
    output logic [7:0] m_pcm_out5
);

    mace6_cmd_t cmd;
    pcm_byte_t  pcm [6];

    mace6_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    mace6_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .s_code_byte (s_code_byte),
        .s_restart   (s_restart),
        .pcm_out     (pcm)
    );

    assign m_pcm_out0 = pcm[0];
    assign m_pcm_out1 = pcm[1];
    assign m_pcm_out2 = pcm[2];
    assign m_pcm_out3 = pcm[3];
    assign m_pcm_out4 = pcm[4];
    assign m_pcm_out5 = pcm[5];

endmodule

// ----- hw/rtl/mace6_checker.sv -----
// port-level checks for the decoder, bound to the top level
module mace6_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_pcm_out0,
    input logic [7:0] m_pcm_out5
);

    // a result is never withdrawn before it is taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("m_valid dropped while stalled");

    // a stalled result keeps its samples
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_pcm_out0) && $stable(m_pcm_out5))
        else $error("result changed while stalled");

    // decoding a byte keeps the input side busy after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready ##1 !s_ready)
        else $error("input taken again too early");

    // after reset the decoder is empty and ready
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("bad state after reset");

endmodule

bind mace6_audio_decoder mace6_checker u_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_pcm_out0 (m_pcm_out0),
    .m_pcm_out5 (m_pcm_out5)
);

// ----- test/mace6_audio_decoder_test.sv -----
// self-checking testbench for the 6:1 audio decoder
module mace6_audio_decoder_test
    import mace6_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [5:0][7:0] pcm_set_t;     // [k] is pcm_out k

    typedef struct packed {
        logic [7:0] code;
        logic       restart;
        logic       known;                  // pcm holds the expected samples
        pcm_set_t   pcm;
    } stim_row_t;

    localparam int DIRECTED_COUNT = 23;
    localparam int RANDOM_COUNT   = 2000;
    localparam int IDLE_PERCENT   = 17;

    // loud bytes push the step index up, quiet ones let it fall back
    typedef enum logic [1:0] {MIX_ANY, MIX_LOUD, MIX_QUIET} byte_mix_t;

    localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{8'h00, 1'b0, 1'b1, {6{8'h80}}},   // state straight out of reset
        '{8'hFF, 1'b1, 1'b1, {6{8'h7F}}},   // most negative codes from cleared state
        '{8'h00, 1'b1, 1'b1, {6{8'h80}}},
        '{8'h6B, 1'b0, 1'b0, '0},           // largest positive slopes, run into saturation
        '{8'h6B, 1'b0, 1'b0, '0},
        '{8'h6B, 1'b0, 1'b0, '0},
        '{8'h6B, 1'b0, 1'b0, '0},
        '{8'h6B, 1'b0, 1'b0, '0},
        '{8'h6B, 1'b0, 1'b0, '0},
        '{8'h6B, 1'b0, 1'b0, '0},
        '{8'h6B, 1'b0, 1'b0, '0},
        '{8'h94, 1'b0, 1'b0, '0},           // largest negative slopes
        '{8'h94, 1'b0, 1'b0, '0},
        '{8'h94, 1'b0, 1'b0, '0},
        '{8'h94, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b1, 1'b1, {6{8'h7F}}},   // restart from a busy state
        '{8'h24, 1'b0, 1'b0, '0},
        '{8'h4D, 1'b0, 1'b0, '0},
        '{8'hB6, 1'b0, 1'b0, '0},
        '{8'hDB, 1'b0, 1'b0, '0},
        '{8'hE7, 1'b0, 1'b0, '0},
        '{8'h18, 1'b0, 1'b0, '0},
        '{8'h81, 1'b0, 1'b0, '0}
    };

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_code_byte = 8'h00;
    logic       s_restart = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_pcm_out0, m_pcm_out1, m_pcm_out2, m_pcm_out3, m_pcm_out4, m_pcm_out5;

    // decoder state as predicted
    int step_idx = 0;
    int energy = 0;
    int hist1 = 0;                          // last sample
    int hist2 = 0;                          // the one before

    pcm_set_t pcm_expected [$];
    int mismatches = 0;

    mace6_audio_decoder uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_code_byte (s_code_byte),
        .s_restart   (s_restart),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pcm_out0  (m_pcm_out0),
        .m_pcm_out1  (m_pcm_out1),
        .m_pcm_out2  (m_pcm_out2),
        .m_pcm_out3  (m_pcm_out3),
        .m_pcm_out4  (m_pcm_out4),
        .m_pcm_out5  (m_pcm_out5)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int clip_sample(input int v);
        int lim;
        lim = SAMPLE_MAX;
        if (v > lim) begin
            return lim;
        end else if (v < -lim) begin
            return -lim;
        end
        return v;
    endfunction

    function automatic pcm_byte_t pcm_of(input int v);
        int c;
        c = clip_sample(v);
        return pcm_byte_t'(c >>> 8) ^ SIGN_FLIP;
    endfunction

    // one adaptive step; wide codes use the 3-bit tables
    function automatic int next_sample(input int code, input bit wide);
        int row;
        int slope;
        int adj;
        int nxt;
        int s;
        row = (step_idx >> 4) & 127;
        if (wide) begin
            slope = code < 4 ? int'(SLOPE3_ROM[row][code]) : -int'(SLOPE3_ROM[row][7 - code]) - 1;
            adj = STEP3_ADJ[code];
        end else begin
            slope = code < 2 ? int'(SLOPE2_ROM[row][code]) : -int'(SLOPE2_ROM[row][3 - code]) - 1;
            adj = STEP2_ADJ[code];
        end
        nxt = step_idx + adj - (step_idx >> 5);
        step_idx = nxt < 0 ? 0 : nxt;
        s = clip_sample(slope + energy);
        energy = (s * s) >>> 15;
        return s;
    endfunction

    function automatic pcm_set_t decode_byte(input logic [7:0] b, input logic restart);
        pcm_set_t pcm;
        int t;
        int half;
        if (restart) begin
            step_idx = 0;
            energy = 0;
            hist1 = 0;
            hist2 = 0;
        end
        for (int k = 0; k < 3; k++) begin
            case (2'(k))
                CODE_HI:  t = next_sample(int'(b[7:5]), 1'b1);
                CODE_MID: t = next_sample(int'(b[4:3]), 1'b0);
                default:  t = next_sample(int'(b[2:0]), 1'b1);
            endcase
            half = hist1 >>> 1;
            pcm[2 * k]     = pcm_of((t >>> 3) + ((hist2 * 3) >>> 3) + half);
            pcm[2 * k + 1] = pcm_of((hist2 >>> 3) + ((t * 3) >>> 3) + half);
            hist2 = hist1;
            hist1 = t;
        end
        return pcm;
    endfunction

    function automatic logic [7:0] pick_byte(input byte_mix_t mix);
        logic [7:0] b;
        case (mix)
            MIX_LOUD:  b = {3'($urandom_range(4, 3)), 2'($urandom_range(2, 1)),
                            3'($urandom_range(4, 3))};
            MIX_QUIET: b = {($urandom_range(1) != 0) ? 3'd7 : 3'd0,
                            ($urandom_range(1) != 0) ? 2'd3 : 2'd0,
                            ($urandom_range(1) != 0) ? 3'd7 : 3'd0};
            default:   b = 8'($urandom_range(255));
        endcase
        return b;
    endfunction

    // offer one byte, hold it until taken, then queue what it should produce
    task automatic send_byte(input logic [7:0] b, input logic restart, input bit calm,
                             input bit known, input pcm_set_t typed);
        pcm_set_t predicted;
        while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_code_byte <= b;
        s_restart   <= restart;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = decode_byte(b, restart);
        pcm_expected.push_back(known ? typed : predicted);
    endtask

    // receiver: random back-pressure, one long hold-off, a calm window
    initial begin
        int cycle;
        int hold_left;
        cycle = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            cycle++;
            if (cycle == 2500) begin
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (cycle > 8000 && cycle < 12000) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= $urandom_range(99) >= IDLE_PERCENT;
            end
        end
    end

    always @(posedge aclk) begin
        pcm_set_t got;
        pcm_set_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_pcm_out5, m_pcm_out4, m_pcm_out3, m_pcm_out2, m_pcm_out1, m_pcm_out0};
            if (pcm_expected.size() == 0) begin
                $display("%0t: result with nothing outstanding, expected none, got %h",
                         $time, got);
                mismatches++;
            end else begin
                want = pcm_expected.pop_front();
                for (int k = 0; k < 6; k++) begin
                    if (got[k] !== want[k]) begin
                        $display("%0t: pcm_out%0d expected %02h, got %02h",
                                 $time, k, want[k], got[k]);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial begin
        byte_mix_t  mix;
        int         run_left;
        logic [7:0] b;
        mix = MIX_ANY;
        run_left = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED_ROWS[i]) begin
            send_byte(DIRECTED_ROWS[i].code, DIRECTED_ROWS[i].restart, 1'b0,
                      DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].pcm);
        end

        for (int n = 0; n < RANDOM_COUNT; n++) begin
            if (run_left == 0) begin
                case ($urandom_range(19) / 10 + $urandom_range(1))
                    0:       mix = MIX_QUIET;
                    1:       mix = MIX_ANY;
                    default: mix = MIX_LOUD;
                endcase
                run_left = $urandom_range(40, 1);
            end
            run_left--;
            b = pick_byte(mix);
            send_byte(b, $urandom_range(99) < 3, n >= 800 && n < 1100, 1'b0, '0);
        end
        s_valid <= 1'b0;

        while (pcm_expected.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("mace6_audio_decoder_test OK");
        end else begin
            $display("mace6_audio_decoder_test NOT OK");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("mace6_audio_decoder_test NOT OK");
        $finish;
    end

endmodule
